FILE: rtl/bfuv_pkg.sv
// Shared types and constants for the brush face texture UV projection block.
`timescale 1ns / 1ps
package bfuv_pkg;

  // Projection modes.
  localparam logic [1:0] MODE_STD  = 2'd0;
  localparam logic [1:0] MODE_V220 = 2'd1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_TSIZE  = 3'd1;
  localparam logic [2:0] REG_SCALE  = 3'd2;
  localparam logic [2:0] REG_OFFSET = 3'd3;
  localparam logic [2:0] REG_ROT    = 3'd4;
  localparam logic [2:0] REG_UAXIS  = 3'd5;
  localparam logic [2:0] REG_VAXIS  = 3'd6;
  localparam logic [2:0] REG_NORMAL = 3'd7;

  // Fixed arithmetic widths.
  localparam int FACT_W  = 17;  // Q2.14 factor or its negation
  localparam int OFFSC_W = 32;  // offset times scale
  localparam int SCSZ_W  = 33;  // scale times texture size
  localparam int DEN_W   = 39;  // 64 * scale * size
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] tex_size;
    logic [31:0] scale;
    logic [31:0] offset;
    logic [31:0] rot;
    logic [47:0] u_axis;
    logic [47:0] v_axis;
    logic [47:0] normal;
  } cfg_t;

  // Per-item control carried down the divider pipeline, index 0 is u, 1 is v.
  typedef struct packed {
    logic       zero;
    logic [1:0] neg;
    logic [1:0] num_neg;
    logic [1:0] den_zero;
    logic [1:0] ovf;
  } ctl_t;

endpackage

FILE: rtl/brush_face_texture_uv_projection_top.sv
// Top level of the brush face texture UV projection block.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | in_vertex_x/y/z, signed Q16.8
//  out     | output    | out_valid/out_stall| out_tex_u/v Q16.16, out_saturated
//  cfg     | input     | psel/penable/pready| paddr, pwdata, prdata (64-bit)
//
// One vertex is accepted per cycle while in_stall is low. The path runs through
// two front stages, the queue, a rounding stage, an overflow check, UV_BITS + 1
// divider stages (one quotient bit each, both coordinates in parallel) and the
// output register. The divider pipeline sets the latency; throughput is one beat
// per cycle while out_stall is low. Reset is synchronous and clears all valid
// state; no clearing pass. An output stall freezes the back end, the four-entry
// queue absorbs the front; in_stall rises only on a full queue with f2_valid_r set.
module brush_face_texture_uv_projection_top #(
  parameter int COORD_BITS           = 24,
  parameter int UV_BITS              = 32,
  parameter int DEFAULT_TEXTURE_SIZE = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [UV_BITS-1:0]    out_tex_u,
  output logic signed [UV_BITS-1:0]    out_tex_v,
  output logic                         out_saturated,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [5:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  // Numerator width: the projection shifted by eight or offset*scale shifted by 22.
  localparam int PSUM_W = COORD_BITS + bfuv_pkg::FACT_W + 2;
  localparam int NUM_W  = ((PSUM_W + 8) > (bfuv_pkg::OFFSC_W + 22)) ?
                          (PSUM_W + 9) : (bfuv_pkg::OFFSC_W + 23);
  localparam int DW     = bfuv_pkg::DEN_W;
  localparam int ENT_W  = 1 + 2 * NUM_W + 2 * DW;

  // Configuration registers.
  bfuv_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= 2'd0;
      cfg_r.tex_size <= 32'd0;
      cfg_r.scale    <= 32'h0100_0100;
      cfg_r.offset   <= 32'd0;
      cfg_r.rot      <= 32'h0000_4000;
      cfg_r.u_axis   <= 48'd0;
      cfg_r.v_axis   <= 48'd0;
      cfg_r.normal   <= 48'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        bfuv_pkg::REG_MODE:   cfg_r.mode     <= pwdata[1:0];
        bfuv_pkg::REG_TSIZE:  cfg_r.tex_size <= pwdata[31:0];
        bfuv_pkg::REG_SCALE:  cfg_r.scale    <= pwdata[31:0];
        bfuv_pkg::REG_OFFSET: cfg_r.offset   <= pwdata[31:0];
        bfuv_pkg::REG_ROT:    cfg_r.rot      <= pwdata[31:0];
        bfuv_pkg::REG_UAXIS:  cfg_r.u_axis   <= pwdata[47:0];
        bfuv_pkg::REG_VAXIS:  cfg_r.v_axis   <= pwdata[47:0];
        bfuv_pkg::REG_NORMAL: cfg_r.normal   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Readback is combinational from the addressed register.
  always_comb begin
    unique case (reg_idx)
      bfuv_pkg::REG_MODE:   prdata = 64'(cfg_r.mode);
      bfuv_pkg::REG_TSIZE:  prdata = 64'(cfg_r.tex_size);
      bfuv_pkg::REG_SCALE:  prdata = 64'(cfg_r.scale);
      bfuv_pkg::REG_OFFSET: prdata = 64'(cfg_r.offset);
      bfuv_pkg::REG_ROT:    prdata = 64'(cfg_r.rot);
      bfuv_pkg::REG_UAXIS:  prdata = 64'(cfg_r.u_axis);
      bfuv_pkg::REG_VAXIS:  prdata = 64'(cfg_r.v_axis);
      bfuv_pkg::REG_NORMAL: prdata = 64'(cfg_r.normal);
      default:              prdata = 64'd0;
    endcase
  end

  // Front end to queue.
  logic                    q_push, q_full, q_pop, q_empty, f_zero, b_zero;
  logic signed [NUM_W-1:0] f_num_u, f_num_v, b_num_u, b_num_v;
  logic signed [DW-1:0]    f_den_u, f_den_v, b_den_u, b_den_v;
  logic [ENT_W-1:0]        q_din, q_dout;

  bfuv_front #(
    .COORD_BITS           (COORD_BITS),
    .DEFAULT_TEXTURE_SIZE (DEFAULT_TEXTURE_SIZE),
    .NUM_W                (NUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vx       (in_vertex_x),
    .vy       (in_vertex_y),
    .vz       (in_vertex_z),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_zero   (f_zero),
    .q_num_u  (f_num_u),
    .q_num_v  (f_num_v),
    .q_den_u  (f_den_u),
    .q_den_v  (f_den_v)
  );

  assign q_din = {f_zero, f_num_u, f_num_v, f_den_u, f_den_v};

  bfuv_fifo #(
    .W     (ENT_W),
    .DEPTH (bfuv_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_zero, b_num_u, b_num_v, b_den_u, b_den_v} = q_dout;

  bfuv_back #(
    .NUM_W   (NUM_W),
    .UV_BITS (UV_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_zero        (b_zero),
    .q_num_u       (b_num_u),
    .q_num_v       (b_num_v),
    .q_den_u       (b_den_u),
    .q_den_v       (b_den_v),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tex_u     (out_tex_u),
    .out_tex_v     (out_tex_v),
    .out_saturated (out_saturated)
  );

endmodule

FILE: rtl/bfuv_front.sv
// Front end: axis selection, projection products and numerator/denominator build.
`timescale 1ns / 1ps
module bfuv_front #(
  parameter int COORD_BITS           = 24,
  parameter int DEFAULT_TEXTURE_SIZE = 512,
  parameter int NUM_W                = 55
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic signed [COORD_BITS-1:0] vz,
  input  bfuv_pkg::cfg_t               cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output logic                         q_zero,
  output logic signed [NUM_W-1:0]      q_num_u,
  output logic signed [NUM_W-1:0]      q_num_v,
  output logic signed [bfuv_pkg::DEN_W-1:0] q_den_u,
  output logic signed [bfuv_pkg::DEN_W-1:0] q_den_v
);

  localparam int PROD_W = COORD_BITS + bfuv_pkg::FACT_W;
  localparam int PSUM_W = PROD_W + 2;

  logic f_adv;
  logic f1_valid_r, f2_valid_r;

  logic signed [16:0] nx, ny, nz;
  logic               up, right;
  logic signed [COORD_BITS-1:0] a, bc;
  logic signed [bfuv_pkg::FACT_W-1:0] c, s, cn;
  logic signed [COORD_BITS-1:0] uc [3];
  logic signed [COORD_BITS-1:0] vc [3];
  logic signed [bfuv_pkg::FACT_W-1:0] uf [3];
  logic signed [bfuv_pkg::FACT_W-1:0] vf [3];

  logic signed [PROD_W-1:0] pu_r [3];
  logic signed [PROD_W-1:0] pv_r [3];
  logic signed [bfuv_pkg::OFFSC_W-1:0] osu_r, osv_r;
  logic signed [bfuv_pkg::SCSZ_W-1:0]  ssu_r, ssv_r;
  logic zero1_r;

  logic [15:0] w_sel, h_sel;
  logic signed [15:0] sx, sy, ox, oy;
  logic signed [PSUM_W-1:0] psum_u, psum_v;

  logic signed [NUM_W-1:0] num_u_r, num_v_r;
  logic signed [bfuv_pkg::DEN_W-1:0] den_u_r, den_v_r;
  logic zero2_r;

  function automatic logic signed [16:0] abs17(input logic [15:0] f);
    logic signed [16:0] e;
    e = 17'(signed'(f));
    return (e < 0) ? -e : e;
  endfunction

  // The whole front moves together; it holds only when its last stage can't drain.
  assign f_adv    = !(f2_valid_r && q_full);
  assign in_stall = !f_adv;
  assign q_push   = f2_valid_r && f_adv;

  always_comb begin
    nx = abs17(cfg.normal[15:0]);
    ny = abs17(cfg.normal[31:16]);
    nz = abs17(cfg.normal[47:32]);
    up    = (nz >= ny) && (nz >= nx);
    right = (ny >= nz) && (ny >= nx);
    a  = (up || right) ? vx : vy;
    bc = up ? vy : vz;
    c  = 17'(signed'(cfg.rot[15:0]));
    s  = 17'(signed'(cfg.rot[31:16]));
    cn = -c;
    for (int i = 0; i < 3; i++) begin
      uc[i] = '0; vc[i] = '0; uf[i] = '0; vf[i] = '0;
    end
    case (cfg.mode)
      bfuv_pkg::MODE_STD: begin
        uc[0] = a;  uf[0] = c;
        uc[1] = bc; uf[1] = s;
        vc[0] = a;  vf[0] = s;
        vc[1] = bc; vf[1] = cn;
      end
      bfuv_pkg::MODE_V220: begin
        uc[0] = vx; uf[0] = 17'(signed'(cfg.u_axis[15:0]));
        uc[1] = vy; uf[1] = 17'(signed'(cfg.u_axis[31:16]));
        uc[2] = vz; uf[2] = 17'(signed'(cfg.u_axis[47:32]));
        vc[0] = vx; vf[0] = 17'(signed'(cfg.v_axis[15:0]));
        vc[1] = vy; vf[1] = 17'(signed'(cfg.v_axis[31:16]));
        vc[2] = vz; vf[2] = 17'(signed'(cfg.v_axis[47:32]));
      end
      default: ;
    endcase
    sx = signed'(cfg.scale[15:0]);
    sy = signed'(cfg.scale[31:16]);
    ox = signed'(cfg.offset[15:0]);
    oy = signed'(cfg.offset[31:16]);
    if (cfg.tex_size[15:0] == 16'd0) begin
      w_sel = 16'(DEFAULT_TEXTURE_SIZE);
      h_sel = 16'(DEFAULT_TEXTURE_SIZE);
    end else begin
      w_sel = cfg.tex_size[15:0];
      h_sel = cfg.tex_size[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      for (int i = 0; i < 3; i++) begin
        pu_r[i] <= uc[i] * uf[i];
        pv_r[i] <= vc[i] * vf[i];
      end
      osu_r   <= sx * ox;
      osv_r   <= sy * oy;
      ssu_r   <= sx * signed'({1'b0, w_sel});
      ssv_r   <= sy * signed'({1'b0, h_sel});
      zero1_r <= (cfg.mode != bfuv_pkg::MODE_STD) && (cfg.mode != bfuv_pkg::MODE_V220);
    end
  end

  assign psum_u = PSUM_W'(pu_r[0]) + PSUM_W'(pu_r[1]) + PSUM_W'(pu_r[2]);
  assign psum_v = PSUM_W'(pv_r[0]) + PSUM_W'(pv_r[1]) + PSUM_W'(pv_r[2]);

  always_ff @(posedge clk) begin
    if (f_adv) begin
      num_u_r <= (NUM_W'(psum_u) <<< 8) + (NUM_W'(osu_r) <<< 22);
      num_v_r <= (NUM_W'(psum_v) <<< 8) + (NUM_W'(osv_r) <<< 22);
      den_u_r <= bfuv_pkg::DEN_W'(ssu_r) <<< 6;
      den_v_r <= bfuv_pkg::DEN_W'(ssv_r) <<< 6;
      zero2_r <= zero1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (f_adv) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  assign q_zero  = zero2_r;
  assign q_num_u = num_u_r;
  assign q_num_v = num_v_r;
  assign q_den_u = den_u_r;
  assign q_den_v = den_v_r;

endmodule

FILE: rtl/bfuv_fifo.sv
// Short queue between the front end and the divider back end.
`timescale 1ns / 1ps
module bfuv_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: rtl/bfuv_back.sv
// Back end: rounding, pipelined restoring division and saturation for u and v.
`timescale 1ns / 1ps
module bfuv_back #(
  parameter int NUM_W   = 55,
  parameter int UV_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  logic                              q_zero,
  input  logic signed [NUM_W-1:0]           q_num_u,
  input  logic signed [NUM_W-1:0]           q_num_v,
  input  logic signed [bfuv_pkg::DEN_W-1:0] q_den_u,
  input  logic signed [bfuv_pkg::DEN_W-1:0] q_den_v,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [UV_BITS-1:0]         out_tex_u,
  output logic signed [UV_BITS-1:0]         out_tex_v,
  output logic                              out_saturated
);

  localparam int UN_W = NUM_W + 1;
  localparam int QB   = UV_BITS + 1;
  localparam int XW   = UN_W + QB;
  localparam int DW   = bfuv_pkg::DEN_W;

  logic adv;

  // Rounding stage.
  logic                b0_v_r;
  bfuv_pkg::ctl_t      b0_ctl_r;
  logic [UN_W-1:0]     b0_un_r [2];
  logic [DW-1:0]       b0_ud_r [2];

  // Divider stages; index 0 is the overflow-check stage.
  logic                d_v_r   [QB+1];
  bfuv_pkg::ctl_t      d_ctl_r [QB+1];
  logic [UN_W-1:0]     d_rem_r [QB+1][2];
  logic [QB-1:0]       d_q_r   [QB+1][2];
  logic [DW-1:0]       d_ud_r  [QB+1][2];

  logic                out_valid_r, out_sat_r;
  logic [UV_BITS-1:0]  out_u_r, out_v_r;

  logic signed [NUM_W-1:0] num [2];
  logic signed [DW-1:0]    den [2];
  bfuv_pkg::ctl_t          ctl0_nxt, ctl1_nxt;
  logic [UN_W-1:0]         un_nxt [2];
  logic [DW-1:0]           ud_nxt [2];
  logic [UV_BITS-1:0]      res [2];
  logic [1:0]              sat;

  localparam logic [UV_BITS-1:0] MAXV = {1'b0, {(UV_BITS-1){1'b1}}};
  localparam logic [UV_BITS-1:0] MINV = {1'b1, {(UV_BITS-1){1'b0}}};

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign num[0] = q_num_u;
  assign num[1] = q_num_v;
  assign den[0] = q_den_u;
  assign den[1] = q_den_v;

  always_comb begin
    ctl0_nxt = '0;
    ctl0_nxt.zero = q_zero;
    for (int l = 0; l < 2; l++) begin
      ctl0_nxt.num_neg[l]  = num[l] < 0;
      ctl0_nxt.den_zero[l] = den[l] == '0;
      ctl0_nxt.neg[l]      = (num[l] < 0) != (den[l] < 0);
      ud_nxt[l] = (den[l] < 0) ? DW'(-den[l]) : DW'(den[l]);
      un_nxt[l] = ((num[l] < 0) ? UN_W'(-UN_W'(num[l])) : UN_W'(num[l]))
                  + UN_W'(ud_nxt[l] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_ctl_r <= ctl0_nxt;
      for (int l = 0; l < 2; l++) begin
        b0_un_r[l] <= un_nxt[l];
        b0_ud_r[l] <= ud_nxt[l];
      end
    end
  end

  // Overflow check: the quotient would not fit in QB bits.
  always_comb begin
    ctl1_nxt = b0_ctl_r;
    for (int l = 0; l < 2; l++)
      ctl1_nxt.ovf[l] = XW'(b0_un_r[l]) >= (XW'(b0_ud_r[l]) << QB);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ctl_r[0] <= ctl1_nxt;
      for (int l = 0; l < 2; l++) begin
        d_rem_r[0][l] <= b0_un_r[l];
        d_q_r[0][l]   <= '0;
        d_ud_r[0][l]  <= b0_ud_r[l];
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int K = QB - 1 - s;
    logic [XW-1:0] dsh [2];
    logic          ge  [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        dsh[l] = XW'(d_ud_r[s][l]) << K;
        ge[l]  = XW'(d_rem_r[s][l]) >= dsh[l];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_ctl_r[s+1] <= d_ctl_r[s];
        for (int l = 0; l < 2; l++) begin
          d_ud_r[s+1][l]  <= d_ud_r[s][l];
          d_rem_r[s+1][l] <= ge[l] ? d_rem_r[s][l] - dsh[l][UN_W-1:0] : d_rem_r[s][l];
          d_q_r[s+1][l]   <= d_q_r[s][l] | (ge[l] ? (QB'(1) << K) : '0);
        end
      end
    end
  end

  always_comb begin
    logic [QB-1:0] q, qn;
    bfuv_pkg::ctl_t c;
    c = d_ctl_r[QB];
    for (int l = 0; l < 2; l++) begin
      q  = d_q_r[QB][l];
      qn = -q;
      sat[l] = 1'b0;
      res[l] = '0;
      if (c.zero) begin
        res[l] = '0;
      end else if (c.den_zero[l]) begin
        sat[l] = 1'b1;
        res[l] = c.num_neg[l] ? MINV : MAXV;
      end else if (c.ovf[l]) begin
        sat[l] = 1'b1;
        res[l] = c.neg[l] ? MINV : MAXV;
      end else if (c.neg[l]) begin
        if (q > QB'(MINV)) begin
          sat[l] = 1'b1;
          res[l] = MINV;
        end else begin
          res[l] = qn[UV_BITS-1:0];
        end
      end else begin
        if (q > QB'(MAXV)) begin
          sat[l] = 1'b1;
          res[l] = MAXV;
        end else begin
          res[l] = q[UV_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_u_r   <= res[0];
      out_v_r   <= res[1];
      out_sat_r <= |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= QB; i++) d_v_r[i] <= 1'b0;
    end else if (adv) begin
      b0_v_r   <= !q_empty;
      d_v_r[0] <= b0_v_r;
      for (int i = 1; i <= QB; i++) d_v_r[i] <= d_v_r[i-1];
      out_valid_r <= d_v_r[QB];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tex_u     = signed'(out_u_r);
  assign out_tex_v     = signed'(out_v_r);
  assign out_saturated = out_sat_r;

endmodule

FILE: rtl/bfuv_checker.sv
// Port-level assertions for the texture UV projection block, with its bind.
`timescale 1ns / 1ps
module bfuv_checker #(
  parameter int UV_BITS = 32
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [UV_BITS-1:0] out_tex_u,
  input logic [UV_BITS-1:0] out_tex_v,
  input logic               out_saturated,
  input logic               pready
);

  localparam logic [UV_BITS-1:0] MAXV = {1'b0, {(UV_BITS-1){1'b1}}};
  localparam logic [UV_BITS-1:0] MINV = {1'b1, {(UV_BITS-1){1'b0}}};

  // A result held under stall keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tex_u) && $stable(out_tex_v)
      && $stable(out_saturated))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A saturated beat carries at least one coordinate at a range limit.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_tex_u == MAXV) || (out_tex_u == MINV)
      || (out_tex_v == MAXV) || (out_tex_v == MINV))
    else $error("saturated flag without a limit value");

  // The configuration port never inserts wait states.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind brush_face_texture_uv_projection_top bfuv_checker #(.UV_BITS(UV_BITS)) u_bfuv_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tex_u     (out_tex_u),
  .out_tex_v     (out_tex_v),
  .out_saturated (out_saturated),
  .pready        (pready)
);

FILE: tb/sv/brush_face_texture_uv_projection_top_tb.sv
// Self-checking testbench for the brush face texture UV projection block.
`timescale 1ns / 1ps
module brush_face_texture_uv_projection_top_tb;

  localparam int COORD_BITS = 24;
  localparam int UV_BITS    = 32;
  localparam int TEX_DEFAULT = 512;
  // The divider pipeline sets the latency of the block.
  localparam int PIPE_LATENCY = UV_BITS + 7;
  // Projection mode codes that have no projection and return zeros.
  localparam logic [1:0] MODE_UNUSED_LO = 2'd2;
  localparam logic [1:0] MODE_UNUSED_HI = 2'd3;

  // One expected beat on the result channel.
  typedef struct {
    logic signed [UV_BITS-1:0] tex_u;
    logic signed [UV_BITS-1:0] tex_v;
    logic                      saturated;
  } uv_beat_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] in_vertex_x;
  logic signed [COORD_BITS-1:0] in_vertex_y;
  logic signed [COORD_BITS-1:0] in_vertex_z;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [UV_BITS-1:0]    out_tex_u;
  logic signed [UV_BITS-1:0]    out_tex_v;
  logic                         out_saturated;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [5:0]                   paddr;
  logic [63:0]                  pwdata;
  logic [63:0]                  prdata;
  logic                         pready;

  brush_face_texture_uv_projection_top #(
    .COORD_BITS(COORD_BITS),
    .UV_BITS(UV_BITS),
    .DEFAULT_TEXTURE_SIZE(TEX_DEFAULT)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_vertex_z(in_vertex_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Free-running 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the face configuration, kept in step with every register write.
  logic [1:0]  face_mode;
  logic [31:0] face_tex_size;
  logic [31:0] face_scale;
  logic [31:0] face_offset;
  logic [31:0] face_rot;
  logic [47:0] face_u_axis;
  logic [47:0] face_v_axis;
  logic [47:0] face_normal;

  uv_beat_t pending_uv[$];
  int       uv_errors;
  // When clear, both sides run flat out with no gaps or stalls.
  bit       gaps_on;

  // Rounds n/d to the nearest step with ties away from zero, then clamps to the
  // signed UV range. A zero divisor clamps toward the sign of the numerator.
  function automatic longint div_round_clamp(longint n, longint d, inout bit sat);
    longint          maxv;
    longint          minv;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    bit              neg;
    maxv = (64'sd1 <<< (UV_BITS - 1)) - 1;
    minv = -maxv - 1;
    if (d == 0) begin
      sat = 1'b1;
      return (n < 0) ? minv : maxv;
    end
    un = (n < 0) ? longint'(-n) : longint'(n);
    ud = (d < 0) ? longint'(-d) : longint'(d);
    q = (un + ud / 2) / ud;
    neg = (n < 0) != (d < 0);
    if (neg) begin
      if (q > longint'(maxv) + 1) begin
        sat = 1'b1;
        return minv;
      end
      return -longint'(q);
    end
    if (q > longint'(maxv)) begin
      sat = 1'b1;
      return maxv;
    end
    return longint'(q);
  endfunction

  // Texture coordinate from a Q.22 projection: (p / scale + offset) / size in Q16.16.
  function automatic longint tex_coord(longint p, longint scl, longint off, longint size,
                                      inout bit sat);
    return div_round_clamp(p * 256 + off * scl * (64'sd1 <<< 22), 64 * scl * size, sat);
  endfunction

  function automatic uv_beat_t predict_uv(logic signed [COORD_BITS-1:0] vx,
                                          logic signed [COORD_BITS-1:0] vy,
                                          logic signed [COORD_BITS-1:0] vz);
    uv_beat_t r;
    longint   x, y, z, w, h, pu, pv, nx, ny, nz, c, s, a, b;
    bit       sat;
    x = longint'(vx);
    y = longint'(vy);
    z = longint'(vz);
    w = longint'(face_tex_size[15:0]);
    h = longint'(face_tex_size[31:16]);
    pu = 0;
    pv = 0;
    sat = 1'b0;
    r.tex_u = '0;
    r.tex_v = '0;
    if (w == 0) begin
      w = TEX_DEFAULT;
      h = TEX_DEFAULT;
    end
    if (face_mode == bfuv_pkg::MODE_STD) begin
      nx = longint'($signed(face_normal[15:0]));
      ny = longint'($signed(face_normal[31:16]));
      nz = longint'($signed(face_normal[47:32]));
      nx = (nx < 0) ? -nx : nx;
      ny = (ny < 0) ? -ny : ny;
      nz = (nz < 0) ? -nz : nz;
      c = longint'($signed(face_rot[15:0]));
      s = longint'($signed(face_rot[31:16]));
      // Dominant axis picks the plane; ties prefer up, then right.
      if (nz >= ny && nz >= nx) begin
        a = x; b = -y;
      end else if (ny >= nx) begin
        a = x; b = -z;
      end else begin
        a = y; b = -z;
      end
      pu = a * c - b * s;
      pv = a * s + b * c;
    end else if (face_mode == bfuv_pkg::MODE_V220) begin
      pu = x * longint'($signed(face_u_axis[15:0])) +
           y * longint'($signed(face_u_axis[31:16])) +
           z * longint'($signed(face_u_axis[47:32]));
      pv = x * longint'($signed(face_v_axis[15:0])) +
           y * longint'($signed(face_v_axis[31:16])) +
           z * longint'($signed(face_v_axis[47:32]));
    end
    if (face_mode == bfuv_pkg::MODE_STD || face_mode == bfuv_pkg::MODE_V220) begin
      r.tex_u = UV_BITS'(tex_coord(pu, longint'($signed(face_scale[15:0])),
                                   longint'($signed(face_offset[15:0])), w, sat));
      r.tex_v = UV_BITS'(tex_coord(pv, longint'($signed(face_scale[31:16])),
                                   longint'($signed(face_offset[31:16])), h, sat));
    end
    r.saturated = sat;
    return r;
  endfunction

  // Drops valid and waits for every expected beat, so registers can be rewritten.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_uv.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write: the pipeline is emptied first, then a setup phase and an
  // access phase; the write lands at the rising edge in the access phase since
  // pready is tied high.
  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      bfuv_pkg::REG_MODE:   face_mode     = value[1:0];
      bfuv_pkg::REG_TSIZE:  face_tex_size = value[31:0];
      bfuv_pkg::REG_SCALE:  face_scale    = value[31:0];
      bfuv_pkg::REG_OFFSET: face_offset   = value[31:0];
      bfuv_pkg::REG_ROT:    face_rot      = value[31:0];
      bfuv_pkg::REG_UAXIS:  face_u_axis   = value[47:0];
      bfuv_pkg::REG_VAXIS:  face_v_axis   = value[47:0];
      bfuv_pkg::REG_NORMAL: face_normal   = value[47:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sends one vertex beat, after a random gap while gaps_on is set, and books its
  // expected result at the edge where it is accepted.
  task automatic send_vertex(logic signed [COORD_BITS-1:0] vx,
                             logic signed [COORD_BITS-1:0] vy,
                             logic signed [COORD_BITS-1:0] vz);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_vertex_x <= vx;
    in_vertex_y <= vy;
    in_vertex_z <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_uv.insert(pending_uv.size(), predict_uv(vx, vy, vz));
  endtask

  // Result side: a random stall stretch before each beat while gaps_on is set.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = gaps_on ? $urandom_range(0, 18) : 0;
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    uv_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_uv.size() == 0) begin
        $display("%0t: unexpected beat u=%h v=%h sat=%b", $time, out_tex_u, out_tex_v,
                 out_saturated);
        uv_errors++;
      end else begin
        exp_beat = pending_uv.pop_front();
        if (out_tex_u !== exp_beat.tex_u) begin
          $display("%0t: tex_u expected %h actual %h", $time, exp_beat.tex_u, out_tex_u);
          uv_errors++;
        end
        if (out_tex_v !== exp_beat.tex_v) begin
          $display("%0t: tex_v expected %h actual %h", $time, exp_beat.tex_v, out_tex_v);
          uv_errors++;
        end
        if (out_saturated !== exp_beat.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_beat.saturated,
                   out_saturated);
          uv_errors++;
        end
      end
    end
  end

  // Reset configuration: zero normal ties every axis, so the up plane is used.
  task automatic test_reset_face();
    send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh000100);
    send_vertex(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
    send_vertex('0, '0, '0);
    drain_results();
  endtask

  // Standard projection: each dominant axis, the tie orders, rotation and offset.
  task automatic test_standard_axes();
    cfg_write(bfuv_pkg::REG_TSIZE, 64'h0040_0080);
    cfg_write(bfuv_pkg::REG_SCALE, 64'h0080_0200);
    cfg_write(bfuv_pkg::REG_OFFSET, 64'hFFF0_0010);
    cfg_write(bfuv_pkg::REG_ROT, 64'h2D41_2D41);
    cfg_write(bfuv_pkg::REG_NORMAL, 64'({16'h0000, 16'h0000, 16'hC000}));  // forward
    send_vertex(24'sh012345, -24'sh004567, 24'sh00ABCD);
    cfg_write(bfuv_pkg::REG_NORMAL, 64'({16'h0000, 16'h4000, 16'h0000}));  // right
    send_vertex(24'sh012345, -24'sh004567, 24'sh00ABCD);
    cfg_write(bfuv_pkg::REG_NORMAL, 64'({16'h2000, 16'hE000, 16'h2000}));  // up ties all
    send_vertex(24'sh012345, -24'sh004567, 24'sh00ABCD);
    cfg_write(bfuv_pkg::REG_NORMAL, 64'({16'h1000, 16'h2000, 16'hE000}));  // right ties
    send_vertex(24'sh012345, -24'sh004567, 24'sh00ABCD);
    cfg_write(bfuv_pkg::REG_NORMAL, 64'({16'h8000, 16'h7FFF, 16'h7FFF}));
    cfg_write(bfuv_pkg::REG_ROT, 64'h8000_8000);
    send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    drain_results();
  endtask

  task automatic test_valve_axes();
    cfg_write(bfuv_pkg::REG_MODE, 64'(bfuv_pkg::MODE_V220));
    cfg_write(bfuv_pkg::REG_UAXIS, 64'({16'h0000, 16'h0000, 16'h4000}));
    cfg_write(bfuv_pkg::REG_VAXIS, 64'({16'hC000, 16'h0000, 16'h0000}));
    send_vertex(24'sh001234, 24'sh005678, -24'sh000100);
    cfg_write(bfuv_pkg::REG_UAXIS, 64'({16'h7FFF, 16'h8000, 16'h7FFF}));
    cfg_write(bfuv_pkg::REG_VAXIS, 64'({16'h8000, 16'h7FFF, 16'h8000}));
    send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_vertex(24'sh800000, 24'sh7FFFFF, 24'sh800000);
    drain_results();
  endtask

  // Zero scale, zero height with a nonzero width, and a plain overflow.
  task automatic test_saturation();
    cfg_write(bfuv_pkg::REG_TSIZE, 64'h0000_0001);
    cfg_write(bfuv_pkg::REG_SCALE, 64'h0000_0000);
    send_vertex(24'sh001000, -24'sh001000, 24'sh000000);
    send_vertex('0, '0, '0);
    cfg_write(bfuv_pkg::REG_SCALE, 64'h0001_FFFF);
    cfg_write(bfuv_pkg::REG_TSIZE, 64'hFFFF_0001);
    cfg_write(bfuv_pkg::REG_OFFSET, 64'h7FFF_8000);
    send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    cfg_write(bfuv_pkg::REG_TSIZE, 64'h0000_FFFF);
    send_vertex(24'sh400000, 24'sh800000, 24'sh123456);
    drain_results();
  endtask

  // Unused projection modes return zeros whatever the vertex.
  task automatic test_unused_modes();
    cfg_write(bfuv_pkg::REG_MODE, 64'(MODE_UNUSED_LO));
    send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    cfg_write(bfuv_pkg::REG_MODE, 64'(MODE_UNUSED_HI));
    send_vertex(24'sh800000, 24'sh7FFFFF, 24'sh800000);
    drain_results();
  endtask

  function automatic logic [15:0] pick_q14();
    case ($urandom_range(0, 4))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 16'h8000) - 16'h4000);
      default: return 16'($urandom());
    endcase
  endfunction

  // Draws a new face; mostly well-scaled values, sometimes full-range registers.
  task automatic randomize_face(bit wild);
    logic [63:0] val;
    if ($urandom_range(0, 9) < 4) val = 64'(bfuv_pkg::MODE_V220);
    else if ($urandom_range(0, 9) == 0) val = 64'(MODE_UNUSED_LO);
    else val = 64'(bfuv_pkg::MODE_STD);
    cfg_write(bfuv_pkg::REG_MODE, val);
    if (wild) begin
      cfg_write(bfuv_pkg::REG_TSIZE, {$urandom(), $urandom()});
      cfg_write(bfuv_pkg::REG_SCALE, {$urandom(), $urandom()});
      cfg_write(bfuv_pkg::REG_OFFSET, {$urandom(), $urandom()});
      cfg_write(bfuv_pkg::REG_ROT, {$urandom(), $urandom()});
    end else begin
      if ($urandom_range(0, 3) == 0) val = 64'd0;
      else val = 64'({16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024))});
      cfg_write(bfuv_pkg::REG_TSIZE, val);
      cfg_write(bfuv_pkg::REG_SCALE,
                64'({16'($urandom_range(16, 1024)), 16'($urandom_range(16, 1024))} ^
                    ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)));
      cfg_write(bfuv_pkg::REG_OFFSET, 64'({16'($urandom_range(0, 512) - 256),
                                           16'($urandom_range(0, 512) - 256)}));
      cfg_write(bfuv_pkg::REG_ROT, 64'({pick_q14(), pick_q14()}));
    end
    cfg_write(bfuv_pkg::REG_UAXIS, 64'({pick_q14(), pick_q14(), pick_q14()}));
    cfg_write(bfuv_pkg::REG_VAXIS, 64'({pick_q14(), pick_q14(), pick_q14()}));
    cfg_write(bfuv_pkg::REG_NORMAL, 64'({pick_q14(), pick_q14(), pick_q14()}));
  endtask

  // Random faces in phases, each with its own run of vertices; every third
  // phase runs without idling on either side.
  task automatic test_random_faces();
    logic [COORD_BITS-1:0] vx, vy, vz;
    for (int phase = 0; phase < 16; phase++) begin
      gaps_on = (phase % 3) != 2;
      randomize_face(phase % 4 == 3);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          vx = COORD_BITS'($urandom());
          vy = COORD_BITS'($urandom());
          vz = COORD_BITS'($urandom());
        end else begin
          vx = COORD_BITS'($urandom_range(0, 24'h00FFFF) - 24'h008000);
          vy = COORD_BITS'($urandom_range(0, 24'h00FFFF) - 24'h008000);
          vz = COORD_BITS'($urandom_range(0, 24'h00FFFF) - 24'h008000);
        end
        send_vertex(vx, vy, vz);
      end
      drain_results();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_vertex_x = '0;
    in_vertex_y = '0;
    in_vertex_z = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    uv_errors   = 0;
    gaps_on     = 1'b1;
    face_mode     = bfuv_pkg::MODE_STD;
    face_tex_size = 32'd0;
    face_scale    = 32'h0100_0100;
    face_offset   = 32'd0;
    face_rot      = 32'h0000_4000;
    face_u_axis   = '0;
    face_v_axis   = '0;
    face_normal   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_face();
    test_standard_axes();
    test_valve_axes();
    test_saturation();
    test_unused_modes();
    test_random_faces();

    drain_results();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (uv_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bfuv_pkg.sv
rtl/bfuv_front.sv
rtl/bfuv_fifo.sv
rtl/bfuv_back.sv
rtl/brush_face_texture_uv_projection_top.sv
rtl/bfuv_checker.sv
tb/sv/brush_face_texture_uv_projection_top_tb.sv
